/* rtl/fpfl_pkg.sv */
// ----------------------------------------------------------------------------
// fpfl_pkg
// Shared types and constants for the fixed pool free list allocator.
// ----------------------------------------------------------------------------
package fpfl_pkg;

    // Field widths of the request and response words
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    // Default pool size
    localparam int POOL_DEPTH_DEF = 64;

    typedef enum logic {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

endpackage

/* rtl/fpfl_link_ram.sv */
// ----------------------------------------------------------------------------
// fpfl_link_ram
// Next-link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpfl_link_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 7
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/fpfl_ctrl.sv */
// ----------------------------------------------------------------------------
// fpfl_ctrl
// Free list control: clearing pass, head and count registers, link store
// accesses and the response register.
// ----------------------------------------------------------------------------
module fpfl_ctrl #(
    parameter int POOL_DEPTH = fpfl_pkg::POOL_DEPTH_DEF,
    parameter int IDX_W      = 6,
    parameter int LINK_W     = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       kind,
    input  logic [fpfl_pkg::SLOT_W-1:0]  slot_index,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [fpfl_pkg::SLOT_W-1:0]  granted_slot,
    output logic                       empty_error,
    output logic [fpfl_pkg::COUNT_W-1:0] free_count,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  logic [LINK_W-1:0]          rd_data,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output logic [LINK_W-1:0]          wr_data
);

    import fpfl_pkg::*;

    // common widths for compares against the narrow port fields
    localparam int CMP_W  = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;
    localparam int WIDE_W = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    count_reg, count_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]    granted_reg, granted_next;
    logic                 error_reg, error_next;
    logic [COUNT_W-1:0]   count_out_reg, count_out_next;

    logic                 out_free;
    logic                 accept;
    logic                 pool_empty;
    logic [CMP_W-1:0]     slot_ext;
    logic                 slot_ok;
    logic [WIDE_W-1:0]    head_wide;
    logic [WIDE_W-1:0]    count_wide;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept     = req_valid && !req_stall;
    assign pool_empty = (count_reg == '0) || (head_reg >= LINK_W'(POOL_DEPTH));
    assign slot_ext   = CMP_W'(slot_index);
    assign slot_ok    = slot_ext < CMP_W'(POOL_DEPTH);
    assign head_wide  = WIDE_W'(head_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        granted_next   = granted_reg;
        error_next     = error_reg;
        count_out_next = count_out_reg;
        count_wide     = WIDE_W'(count_reg);
        rd_en          = 1'b0;
        rd_addr        = head_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = clr_idx_reg;
        wr_data        = LINK_W'(clr_idx_reg) + LINK_W'(1);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // entry i links to i + 1
                wr_en = 1'b1;
                if (clr_idx_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = '0;
                    error_next     = 1'b0;
                    if (kind == KIND_ALLOC)
                    begin
                        if (pool_empty)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            granted_next = head_wide[SLOT_W-1:0];
                            count_next   = count_reg - LINK_W'(1);
                            rd_en        = 1'b1;
                            state_next   = ST_FETCH;
                        end
                    end
                    else if (slot_ok)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = slot_ext[IDX_W-1:0];
                        wr_data   = head_reg;
                        head_next = slot_ext[LINK_W-1:0];
                        if (count_reg < LINK_W'(POOL_DEPTH))
                        begin
                            count_next = count_reg + LINK_W'(1);
                        end
                    end
                    count_wide     = WIDE_W'(count_next);
                    count_out_next = count_wide[COUNT_W-1:0];
                end
            end

            ST_FETCH:
            begin
                // link of the popped slot becomes the new head
                head_next  = rd_data;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            count_reg     <= LINK_W'(POOL_DEPTH);
            rsp_valid_reg <= 1'b0;
            granted_reg   <= '0;
            error_reg     <= 1'b0;
            count_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            granted_reg   <= granted_next;
            error_reg     <= error_next;
            count_out_reg <= count_out_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted_slot = granted_reg;
    assign empty_error  = error_reg;
    assign free_count   = count_out_reg;

endmodule

/* rtl/fixed_pool_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator
// Slot allocator over a fixed pool, free slots kept as an index-linked list
// in a synchronous next-link memory with a head register and a free count.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             word
//  req      in         req_valid/req_stall   kind, slot_index
//  rsp      out        rsp_valid/rsp_stall   granted_slot, empty_error, free_count
//
//  Allocate: goes through ST_FETCH, where the head's registered link becomes the new head.
//  Release and failed allocate: no ST_FETCH; a release of an in-range slot does a single link write.
//  After reset a clearing pass writes every entry of the link memory;
//  req_stall is high throughout.
//  A new word is taken while the controller is idle and the response register is free or being read.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator #(
    parameter int POOL_DEPTH = fpfl_pkg::POOL_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         kind,
    input  logic [fpfl_pkg::SLOT_W-1:0]  slot_index,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [fpfl_pkg::SLOT_W-1:0]  granted_slot,
    output logic                         empty_error,
    output logic [fpfl_pkg::COUNT_W-1:0] free_count
);

    import fpfl_pkg::*;

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    // links also hold the end-of-list mark POOL_DEPTH
    localparam int LINK_W = $clog2(POOL_DEPTH + 1);

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;

    fpfl_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .IDX_W      (IDX_W),
        .LINK_W     (LINK_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .slot_index   (slot_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted_slot (granted_slot),
        .empty_error  (empty_error),
        .free_count   (free_count),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    fpfl_link_ram #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
